// ===== src/convection_stencil_operator_defines.svh =====
// Assertion macros for the file that checks its own logic.
`ifndef CONVECTION_STENCIL_OPERATOR_DEFINES_SVH
`define CONVECTION_STENCIL_OPERATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CSO_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CSO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/cso_pkg.sv =====
`default_nettype none

package cso_pkg;

  // Grid bounds and line store geometry.
  localparam int MAX_ROWS  = 256;
  localparam int MAX_COLS  = 256;
  localparam int SLOTS     = 5;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int MEM_DEPTH = SLOTS * MAX_COLS;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int DIM_W     = 9;
  localparam int CNT_W     = 17;
  localparam int LAG_W     = DIM_W + 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int ACC_W     = 128;
  localparam int DIFF_W    = 40;

  localparam logic [CNT_W-1:0] PEND_MAX = {CNT_W{1'b1}};

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SCHEME = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_DX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_DY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLS   = 3'd4;

  // Difference schemes.
  localparam logic [1:0] SCHEME_UPWIND1 = 2'd0;
  localparam logic [1:0] SCHEME_CENTRAL = 2'd1;
  localparam logic [1:0] SCHEME_UPWIND2 = 2'd2;
  localparam logic [1:0] SCHEME_SPARE   = 2'd3;

  // Request types.
  localparam logic REQ_DATA  = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  // Reset values of the registers.
  localparam logic [1:0]       RST_SCHEME = SCHEME_UPWIND2;
  localparam logic [31:0]      RST_INV    = 32'd6553600;
  localparam logic [DIM_W-1:0] RST_DIM    = 9'd256;

  // Stencil read order.
  localparam logic [3:0] RD_P   = 4'd0;
  localparam logic [3:0] RD_XM  = 4'd1;
  localparam logic [3:0] RD_XP  = 4'd2;
  localparam logic [3:0] RD_YM  = 4'd3;
  localparam logic [3:0] RD_YP  = 4'd4;
  localparam logic [3:0] RD_XMM = 4'd5;
  localparam logic [3:0] RD_XPP = 4'd6;
  localparam logic [3:0] RD_YMM = 4'd7;
  localparam logic [3:0] RD_YPP = 4'd8;
  localparam logic [3:0] RD_LAST = RD_YPP;
  localparam int         NUM_RD  = 9;

  localparam logic [3:0] MUL_LAST = 4'd10;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              wr_en;
    logic [SLOT_W-1:0] wr_slot;
    logic [COL_W-1:0]  wr_col;
    logic              rd_en;
    logic [3:0]        rd_idx;
    logic [ROW_W-1:0]  job_row;
    logic [COL_W-1:0]  job_col;
    logic [SLOT_W-1:0] job_slot;
    logic [1:0]        mode;
    logic              on_edge;
    logic              last;
    logic              diff_en;
    logic              mul_en;
    logic [3:0]        mul_step;
    logic              round_en;
    logic              sat_en;
    logic              out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } status_t;

  // Row slot moved forward by step (0..SLOTS-1), modulo SLOTS.
  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] slot,
                                                  input logic [SLOT_W-1:0] step);
    logic [SLOT_W:0] sum;
    sum = {1'b0, slot} + {1'b0, step};
    if (sum >= (SLOT_W+1)'(SLOTS)) begin
      sum = sum - (SLOT_W+1)'(SLOTS);
    end
    return sum[SLOT_W-1:0];
  endfunction

  // Line store address of a slot and column.
  function automatic logic [ADDR_W-1:0] mem_addr(input logic [SLOT_W-1:0] slot,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(ADDR_W'(slot) * ADDR_W'(MAX_COLS)) + ADDR_W'(col);
  endfunction

endpackage

`default_nettype wire

// ===== src/cso_if.sv =====
`default_nettype none

// Grid point channel.
interface cso_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [31:0] phi_sample;
  logic signed [31:0] u_velocity;
  logic signed [31:0] v_velocity;

  modport source (output valid, req_type, phi_sample, u_velocity, v_velocity,
                  input ready);
  modport sink (input valid, req_type, phi_sample, u_velocity, v_velocity,
                output ready);
endinterface

// Flux result channel.
interface cso_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] flux_value;
  logic [7:0]         row_index;
  logic [7:0]         col_index;
  logic               saturated;
  logic               last_point;

  modport source (output valid, flux_value, row_index, col_index, saturated, last_point,
                  input ready);
  modport sink (input valid, flux_value, row_index, col_index, saturated, last_point,
                output ready);
endinterface

`default_nettype wire

// ===== src/cso_ram.sv =====
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module cso_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/cso_ctrl.sv =====
`default_nettype none

// Sequencer: tracks input and output positions, decides when a point
// is answered and steps the datapath through one flux evaluation.
module cso_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic                         in_req_type,
  output logic                              in_ready,
  input  wire logic [1:0]                   scheme_select,
  input  wire logic [cso_pkg::DIM_W-1:0]    grid_rows,
  input  wire logic [cso_pkg::DIM_W-1:0]    grid_cols,
  input  wire cso_pkg::status_t             status,
  output cso_pkg::cmd_t                     cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_DIFF  = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_ROUND = 7'b0010000,
    S_SAT   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic [3:0] cnt, cnt_next;

  logic [cso_pkg::ROW_W-1:0]  in_row, in_row_next, out_row, out_row_next;
  logic [cso_pkg::COL_W-1:0]  in_col, in_col_next, out_col, out_col_next;
  logic [cso_pkg::SLOT_W-1:0] in_slot, in_slot_next, out_slot, out_slot_next;
  logic [cso_pkg::CNT_W-1:0]  pending, pending_next, pend_inc;

  logic [cso_pkg::ROW_W-1:0]  job_row;
  logic [cso_pkg::COL_W-1:0]  job_col;
  logic [cso_pkg::SLOT_W-1:0] job_slot;
  logic [1:0]                 job_mode, mode_calc;
  logic                       job_edge, job_last, edge_calc, last_calc;

  logic [cso_pkg::DIM_W-1:0] rows_c, cols_c, orow_w, ocol_w;
  logic [cso_pkg::LAG_W-1:0] lag;
  logic accept, data_acc, emit;

  // Clamp the grid dimensions to the supported range.
  always_comb begin
    rows_c = grid_rows;
    if (grid_rows < cso_pkg::DIM_W'(3)) begin
      rows_c = cso_pkg::DIM_W'(3);
    end else if (grid_rows > cso_pkg::DIM_W'(cso_pkg::MAX_ROWS)) begin
      rows_c = cso_pkg::DIM_W'(cso_pkg::MAX_ROWS);
    end
    cols_c = grid_cols;
    if (grid_cols < cso_pkg::DIM_W'(3)) begin
      cols_c = cso_pkg::DIM_W'(3);
    end else if (grid_cols > cso_pkg::DIM_W'(cso_pkg::MAX_COLS)) begin
      cols_c = cso_pkg::DIM_W'(cso_pkg::MAX_COLS);
    end
    lag = cso_pkg::LAG_W'({cols_c, 1'b0}) + cso_pkg::LAG_W'(2);
  end

  // Edge and scheme of the point about to be answered.
  always_comb begin
    orow_w    = cso_pkg::DIM_W'(out_row);
    ocol_w    = cso_pkg::DIM_W'(out_col);
    edge_calc = (orow_w == '0) || (orow_w >= rows_c - 1'b1) ||
                (ocol_w == '0) || (ocol_w >= cols_c - 1'b1);
    last_calc = (orow_w == rows_c - 1'b1) && (ocol_w == cols_c - 1'b1);
    mode_calc = scheme_select;
    if (mode_calc == cso_pkg::SCHEME_SPARE) begin
      mode_calc = cso_pkg::SCHEME_UPWIND2;
    end
    if (mode_calc == cso_pkg::SCHEME_UPWIND2 &&
        (orow_w == cso_pkg::DIM_W'(1) || orow_w == rows_c - cso_pkg::DIM_W'(2) ||
         ocol_w == cso_pkg::DIM_W'(1) || ocol_w == cols_c - cso_pkg::DIM_W'(2))) begin
      mode_calc = cso_pkg::SCHEME_CENTRAL;
    end
  end

  // Position bookkeeping and the emit decision.
  always_comb begin
    in_ready = (state == S_IDLE);
    accept   = in_valid && in_ready;
    data_acc = accept && (in_req_type == cso_pkg::REQ_DATA);
    pend_inc = (pending != cso_pkg::PEND_MAX) ? pending + 1'b1 : pending;
    emit     = (data_acc && (pend_inc > cso_pkg::CNT_W'(lag))) ||
               (accept && (in_req_type == cso_pkg::REQ_DRAIN) && in_row == '0 &&
                in_col == '0 && pending != '0);

    in_row_next  = in_row;
    in_col_next  = in_col;
    in_slot_next = in_slot;
    if (data_acc) begin
      if (cso_pkg::DIM_W'(in_col) + 1'b1 >= cols_c) begin
        in_col_next  = '0;
        in_slot_next = cso_pkg::slot_add(in_slot, cso_pkg::SLOT_W'(1));
        in_row_next  = (cso_pkg::DIM_W'(in_row) + 1'b1 >= rows_c) ? '0 : in_row + 1'b1;
      end else begin
        in_col_next = in_col + 1'b1;
      end
    end

    out_row_next  = out_row;
    out_col_next  = out_col;
    out_slot_next = out_slot;
    if (emit) begin
      if (ocol_w + 1'b1 >= cols_c) begin
        out_col_next  = '0;
        out_slot_next = cso_pkg::slot_add(out_slot, cso_pkg::SLOT_W'(1));
        out_row_next  = (orow_w + 1'b1 >= rows_c) ? '0 : out_row + 1'b1;
      end else begin
        out_col_next = out_col + 1'b1;
      end
    end

    pending_next = data_acc ? pend_inc : pending;
    if (emit) begin
      pending_next = pending_next - 1'b1;
    end
  end

  // State sequencing.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      S_IDLE: begin
        cnt_next = '0;
        if (emit) begin
          state_next = edge_calc ? S_OUT : S_READ;
        end
      end
      S_READ: begin
        cnt_next = cnt + 1'b1;
        if (cnt == cso_pkg::RD_LAST + 1'b1) begin
          state_next = S_DIFF;
        end
      end
      S_DIFF: begin
        cnt_next   = '0;
        state_next = S_MUL;
      end
      S_MUL: begin
        cnt_next = cnt + 1'b1;
        if (cnt == cso_pkg::MUL_LAST) begin
          state_next = S_ROUND;
        end
      end
      S_ROUND: state_next = S_SAT;
      S_SAT:   state_next = S_OUT;
      S_OUT: begin
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd          = '0;
    cmd.wr_en    = data_acc;
    cmd.wr_slot  = in_slot;
    cmd.wr_col   = in_col;
    cmd.rd_en    = (state == S_READ) && (cnt <= cso_pkg::RD_LAST);
    cmd.rd_idx   = cnt;
    cmd.job_row  = job_row;
    cmd.job_col  = job_col;
    cmd.job_slot = job_slot;
    cmd.mode     = job_mode;
    cmd.on_edge  = job_edge;
    cmd.last     = job_last;
    cmd.diff_en  = (state == S_DIFF);
    cmd.mul_en   = (state == S_MUL);
    cmd.mul_step = cnt;
    cmd.round_en = (state == S_ROUND);
    cmd.sat_en   = (state == S_SAT);
    cmd.out_load = (state == S_OUT) && status.out_free;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      in_row   <= '0;
      in_col   <= '0;
      in_slot  <= '0;
      out_row  <= '0;
      out_col  <= '0;
      out_slot <= '0;
      pending  <= '0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      in_row   <= in_row_next;
      in_col   <= in_col_next;
      in_slot  <= in_slot_next;
      out_row  <= out_row_next;
      out_col  <= out_col_next;
      out_slot <= out_slot_next;
      pending  <= pending_next;
    end
  end

  // Job descriptor of the point being answered.
  always_ff @(posedge clk) begin
    if (emit) begin
      job_row  <= out_row;
      job_col  <= out_col;
      job_slot <= out_slot;
      job_mode <= mode_calc;
      job_edge <= edge_calc;
      job_last <= last_calc;
    end
  end

endmodule

`default_nettype wire

// ===== src/cso_dp.sv =====
`default_nettype none

// Datapath: line stores, stencil registers, one shared 32x32 multiplier,
// a 128-bit accumulator, rounding, saturation and the output register.
module cso_dp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cso_pkg::cmd_t      cmd,
  output cso_pkg::status_t        status,
  input  wire logic signed [31:0] phi_in,
  input  wire logic signed [31:0] u_in,
  input  wire logic signed [31:0] v_in,
  input  wire logic [31:0]        inv_dx,
  input  wire logic [31:0]        inv_dy,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_flux,
  output logic [7:0]              out_row,
  output logic [7:0]              out_col,
  output logic                    out_sat,
  output logic                    out_last
);

  typedef enum logic [1:0] {MK_NONE, MK_CX, MK_CY, MK_ACC} mul_kind_t;

  logic [cso_pkg::ADDR_W-1:0] waddr, raddr;
  logic [31:0]                phi_rd;
  logic [63:0]                vel_rd;
  logic [cso_pkg::SLOT_W-1:0] step_k;
  logic [cso_pkg::COL_W-1:0]  step_m;

  logic                       rd_valid_d;
  logic [3:0]                 rd_idx_d;
  logic signed [31:0]         phi_r [cso_pkg::NUM_RD];
  logic [63:0]                vel_r;

  logic signed [cso_pkg::DIFF_W-1:0] p, xm, xp, ym, yp, xmm, xpp, ymm, ypp;
  logic signed [cso_pkg::DIFF_W-1:0] da1x, db1x, da2x, db2x, da1y, db1y, da2y, db2y;
  logic signed [cso_pkg::DIFF_W-1:0] sa1x, sa2x, sa1y, sa2y, ex, ey;
  logic                              un, vn;
  logic [cso_pkg::DIFF_W-1:0]        exm, eym;
  logic                              exn, eyn;

  logic [31:0]     abs_u, abs_v, mul_a, mul_b;
  logic [6:0]      mul_sh, sh_d;
  logic            mul_neg, neg_d;
  mul_kind_t       mul_kind, kind_d;
  logic [63:0]     prod, cx, cy;
  logic [cso_pkg::ACC_W-1:0] acc, acc_r, term, shifted;
  logic            fits;
  logic signed [31:0] res_flux;
  logic            res_sat;

  // Line store ports: write at the input position, read around the job.
  always_comb begin
    waddr = cso_pkg::mem_addr(cmd.wr_slot, cmd.wr_col);
    step_k = '0;
    step_m = '0;
    case (cmd.rd_idx)
      cso_pkg::RD_XM:  step_k = cso_pkg::SLOT_W'(cso_pkg::SLOTS - 1);
      cso_pkg::RD_XP:  step_k = cso_pkg::SLOT_W'(1);
      cso_pkg::RD_XMM: step_k = cso_pkg::SLOT_W'(cso_pkg::SLOTS - 2);
      cso_pkg::RD_XPP: step_k = cso_pkg::SLOT_W'(2);
      cso_pkg::RD_YM:  step_m = '1;
      cso_pkg::RD_YP:  step_m = cso_pkg::COL_W'(1);
      cso_pkg::RD_YMM: step_m = cso_pkg::COL_W'(-2);
      cso_pkg::RD_YPP: step_m = cso_pkg::COL_W'(2);
      default: begin
        step_k = '0;
        step_m = '0;
      end
    endcase
    raddr = cso_pkg::mem_addr(cso_pkg::slot_add(cmd.job_slot, step_k), cmd.job_col + step_m);
  end

  cso_ram #(.WIDTH(32), .DEPTH(cso_pkg::MEM_DEPTH)) u_phi_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (waddr),
    .wdata (phi_in),
    .raddr (raddr),
    .rdata (phi_rd)
  );

  cso_ram #(.WIDTH(64), .DEPTH(cso_pkg::MEM_DEPTH)) u_vel_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (waddr),
    .wdata ({u_in, v_in}),
    .raddr (raddr),
    .rdata (vel_rd)
  );

  // Capture the stencil words one read behind the address.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid_d <= 1'b0;
    end else begin
      rd_valid_d <= cmd.rd_en;
    end
    rd_idx_d <= cmd.rd_idx;
    if (rd_valid_d) begin
      phi_r[rd_idx_d] <= phi_rd;
      if (rd_idx_d == cso_pkg::RD_P) begin
        vel_r <= vel_rd;
      end
    end
  end

  // Exact integer difference combinations for each direction.
  always_comb begin
    p   = cso_pkg::DIFF_W'(phi_r[cso_pkg::RD_P]);
    xm  = cso_pkg::DIFF_W'(phi_r[cso_pkg::RD_XM]);
    xp  = cso_pkg::DIFF_W'(phi_r[cso_pkg::RD_XP]);
    ym  = cso_pkg::DIFF_W'(phi_r[cso_pkg::RD_YM]);
    yp  = cso_pkg::DIFF_W'(phi_r[cso_pkg::RD_YP]);
    xmm = cso_pkg::DIFF_W'(phi_r[cso_pkg::RD_XMM]);
    xpp = cso_pkg::DIFF_W'(phi_r[cso_pkg::RD_XPP]);
    ymm = cso_pkg::DIFF_W'(phi_r[cso_pkg::RD_YMM]);
    ypp = cso_pkg::DIFF_W'(phi_r[cso_pkg::RD_YPP]);
    un  = vel_r[63];
    vn  = vel_r[31];

    da1x = xp - xm;
    db1x = xp - (p <<< 1) + xm;
    da2x = (xp <<< 2) - (xm <<< 2) + xmm - xpp;
    db2x = (p <<< 2) + (p <<< 1) - (xm <<< 2) + xmm - (xp <<< 2) + xpp;
    da1y = yp - ym;
    db1y = yp - (p <<< 1) + ym;
    da2y = (yp <<< 2) - (ym <<< 2) + ymm - ypp;
    db2y = (p <<< 2) + (p <<< 1) - (ym <<< 2) + ymm - (yp <<< 2) + ypp;

    sa1x = un ? -da1x : da1x;
    sa2x = un ? -da2x : da2x;
    sa1y = vn ? -da1y : da1y;
    sa2y = vn ? -da2y : da2y;

    case (cmd.mode)
      cso_pkg::SCHEME_UPWIND1: begin
        ex = sa1x - db1x;
        ey = sa1y - db1y;
      end
      cso_pkg::SCHEME_CENTRAL: begin
        ex = sa1x;
        ey = sa1y;
      end
      default: begin
        ex = sa2x + db2x;
        ey = sa2y + db2y;
      end
    endcase
  end

  // Register the difference magnitudes and signs.
  always_ff @(posedge clk) begin
    if (cmd.diff_en) begin
      exn <= ex[cso_pkg::DIFF_W-1];
      eyn <= ey[cso_pkg::DIFF_W-1];
      exm <= ex[cso_pkg::DIFF_W-1] ? cso_pkg::DIFF_W'(-ex) : cso_pkg::DIFF_W'(ex);
      eym <= ey[cso_pkg::DIFF_W-1] ? cso_pkg::DIFF_W'(-ey) : cso_pkg::DIFF_W'(ey);
    end
  end

  // Multiplier schedule: coefficients first, then four partial products
  // per direction.
  always_comb begin
    abs_u    = un ? 32'(-$signed(vel_r[63:32])) : vel_r[63:32];
    abs_v    = vn ? 32'(-$signed(vel_r[31:0])) : vel_r[31:0];
    mul_a    = '0;
    mul_b    = '0;
    mul_sh   = '0;
    mul_neg  = 1'b0;
    mul_kind = MK_NONE;
    case (cmd.mul_step)
      4'd0: begin mul_a = abs_u; mul_b = inv_dx; mul_kind = MK_CX; end
      4'd1: begin mul_a = abs_v; mul_b = inv_dy; mul_kind = MK_CY; end
      4'd2: begin
        mul_a = cx[31:0]; mul_b = exm[31:0]; mul_sh = 7'd0;
        mul_neg = exn; mul_kind = MK_ACC;
      end
      4'd3: begin
        mul_a = cx[31:0]; mul_b = 32'(exm[cso_pkg::DIFF_W-1:32]); mul_sh = 7'd32;
        mul_neg = exn; mul_kind = MK_ACC;
      end
      4'd4: begin
        mul_a = cx[63:32]; mul_b = exm[31:0]; mul_sh = 7'd32;
        mul_neg = exn; mul_kind = MK_ACC;
      end
      4'd5: begin
        mul_a = cx[63:32]; mul_b = 32'(exm[cso_pkg::DIFF_W-1:32]); mul_sh = 7'd64;
        mul_neg = exn; mul_kind = MK_ACC;
      end
      4'd6: begin
        mul_a = cy[31:0]; mul_b = eym[31:0]; mul_sh = 7'd0;
        mul_neg = eyn; mul_kind = MK_ACC;
      end
      4'd7: begin
        mul_a = cy[31:0]; mul_b = 32'(eym[cso_pkg::DIFF_W-1:32]); mul_sh = 7'd32;
        mul_neg = eyn; mul_kind = MK_ACC;
      end
      4'd8: begin
        mul_a = cy[63:32]; mul_b = eym[31:0]; mul_sh = 7'd32;
        mul_neg = eyn; mul_kind = MK_ACC;
      end
      4'd9: begin
        mul_a = cy[63:32]; mul_b = 32'(eym[cso_pkg::DIFF_W-1:32]); mul_sh = 7'd64;
        mul_neg = eyn; mul_kind = MK_ACC;
      end
      default: mul_kind = MK_NONE;
    endcase
    term = cso_pkg::ACC_W'(prod) << sh_d;
  end

  // Product register and accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      kind_d <= MK_NONE;
    end else begin
      kind_d <= cmd.mul_en ? mul_kind : MK_NONE;
    end
    prod  <= mul_a * mul_b;
    sh_d  <= mul_sh;
    neg_d <= mul_neg;
    if (kind_d == MK_CX) begin
      cx <= prod;
    end
    if (kind_d == MK_CY) begin
      cy <= prod;
    end
    if (cmd.diff_en) begin
      acc <= '0;
    end else if (kind_d == MK_ACC) begin
      acc <= neg_d ? acc - term : acc + term;
    end
  end

  // Round to nearest, then scale by one half or one quarter and saturate.
  always_comb begin
    if (cmd.mode == cso_pkg::SCHEME_UPWIND2) begin
      shifted = $signed(acc_r) >>> 34;
    end else begin
      shifted = $signed(acc_r) >>> 33;
    end
    fits = (shifted[cso_pkg::ACC_W-1:31] == '0) || (shifted[cso_pkg::ACC_W-1:31] == '1);
  end

  always_ff @(posedge clk) begin
    if (cmd.round_en) begin
      acc_r <= (cmd.mode == cso_pkg::SCHEME_UPWIND2) ?
               acc + (cso_pkg::ACC_W'(1) << 33) : acc + (cso_pkg::ACC_W'(1) << 32);
    end
    if (cmd.sat_en) begin
      res_sat <= !fits;
      if (fits) begin
        res_flux <= shifted[31:0];
      end else begin
        res_flux <= acc_r[cso_pkg::ACC_W-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
      end
    end
  end

  // Output register: holds a finished word until the receiver takes it.
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      out_flux <= cmd.on_edge ? '0 : res_flux;
      out_sat  <= cmd.on_edge ? 1'b0 : res_sat;
      out_row  <= 8'(cmd.job_row);
      out_col  <= 8'(cmd.job_col);
      out_last <= cmd.last;
    end
  end

endmodule

`default_nettype wire

// ===== src/convection_stencil_operator.sv =====
// Streaming 2-D convective flux stencil.
// Grid points enter on the samples channel in raster order (row outer,
// column inner); a word with req_type set is a drain tick that flushes one
// pending result once the whole grid has been received. Each point's flux
// leaves on the results channel, 2*cols+2 points after the point entered.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user
// must do so only while idle, as the block itself does not enforce it. A
// word that answers an edge point goes straight to the output load; an
// interior point takes nine line store reads through a single read port
// plus a capture step, differences, the shared 32x32 multiplier, rounding,
// saturation and the output load. Results go to an output register, so the
// next word is taken while a result waits; if the receiver stalls, a second
// finished result waits inside until the register frees. Reset clears the
// positions, the pending count and the output register and loads the
// register defaults; the line stores need no clearing.
`default_nettype none
`include "convection_stencil_operator_defines.svh"

module convection_stencil_operator (
  input  wire logic                           clk,
  input  wire logic                           rst,
  cso_in_if.sink                              samples,
  cso_out_if.source                           results,
  input  wire logic                           cfg_we,
  input  wire logic [cso_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cso_pkg::CFG_W-1:0]      cfg_data
);

  logic [1:0]                scheme_select;
  logic [31:0]               inv_dx, inv_dy;
  logic [cso_pkg::DIM_W-1:0] grid_rows, grid_cols;
  cso_pkg::cmd_t             cmd;
  cso_pkg::status_t          status;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      scheme_select <= cso_pkg::RST_SCHEME;
      inv_dx        <= cso_pkg::RST_INV;
      inv_dy        <= cso_pkg::RST_INV;
      grid_rows     <= cso_pkg::RST_DIM;
      grid_cols     <= cso_pkg::RST_DIM;
    end else if (cfg_we) begin
      case (cfg_index)
        cso_pkg::REG_SCHEME: scheme_select <= cfg_data[1:0];
        cso_pkg::REG_INV_DX: inv_dx        <= cfg_data;
        cso_pkg::REG_INV_DY: inv_dy        <= cfg_data;
        cso_pkg::REG_ROWS:   grid_rows     <= cfg_data[cso_pkg::DIM_W-1:0];
        cso_pkg::REG_COLS:   grid_cols     <= cfg_data[cso_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  cso_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (samples.valid),
    .in_req_type   (samples.req_type),
    .in_ready      (samples.ready),
    .scheme_select (scheme_select),
    .grid_rows     (grid_rows),
    .grid_cols     (grid_cols),
    .status        (status),
    .cmd           (cmd)
  );

  cso_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .phi_in    (samples.phi_sample),
    .u_in      (samples.u_velocity),
    .v_in      (samples.v_velocity),
    .inv_dx    (inv_dx),
    .inv_dy    (inv_dy),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_flux  (results.flux_value),
    .out_row   (results.row_index),
    .out_col   (results.col_index),
    .out_sat   (results.saturated),
    .out_last  (results.last_point)
  );

  // A result is never loaded over a word the receiver has not taken.
  `CSO_ASSERT_SAME(a_load_free, cmd.out_load, status.out_free, "result loaded over waiting word")
  // Input words are taken only while no evaluation is in flight.
  `CSO_ASSERT_SAME(a_accept_idle, samples.valid && samples.ready,
                   !cmd.rd_en && !cmd.mul_en && !cmd.out_load, "word taken while busy")
  // A loaded result is offered on the next cycle.
  `CSO_ASSERT_NEXT(a_load_shows, cmd.out_load, results.valid, "loaded result not offered")

endmodule

`default_nettype wire
